// ----- rtl/cscan_pkg.sv -----
// ----------------------------------------------------------------------------
// cscan_pkg
// Shared types and constants for the circular-scan disk scheduler.
// ----------------------------------------------------------------------------
package cscan_pkg;

  localparam int MAX_REQUESTS = 32;
  localparam int CYL_W        = 16;
  localparam int SEEK_W       = 17;
  localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
  localparam int IDX_W        = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam logic [CYL_W-1:0] MAX_CYL_RESET = CYL_W'(199);

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_START = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_SCAN,
    ST_SEEK,
    ST_DIV,
    ST_EMIT_RD,
    ST_EMIT
  } state_t;

  // emission phases
  typedef enum logic [2:0] {
    PH_HEAD,
    PH_EQ,
    PH_SIDE1,
    PH_END1,
    PH_END2,
    PH_SIDE2
  } phase_t;

  typedef struct packed {
    logic load;        // store incoming request
    logic clear;       // drop count and overflow
    logic sort_init;   // reset sort and scan pointers and bounds
    logic sort_rd;     // read sorted entries
    logic sort_step;   // one compare/shift step
    logic scan_step;   // one scan step over sorted list
    logic div_init;
    logic div_step;
    logic emit_adv;    // result taken, advance
  } cmd_t;

  typedef struct packed {
    logic sort_done;
    logic sort_ins;    // insertion point found
    logic scan_done;
    logic div_done;
    logic emit_last;
  } sts_t;

endpackage

// ----- rtl/cscan_if.sv -----
// ----------------------------------------------------------------------------
// cscan_if
// Valid/ready channels: request input, result output, configuration write.
// ----------------------------------------------------------------------------
interface cscan_in_if;
  import cscan_pkg::*;
  logic             valid;
  logic             ready;
  logic             mode;
  logic [CYL_W-1:0] cylinder;
  modport source (output valid, mode, cylinder, input ready);
  modport sink   (input valid, mode, cylinder, output ready);
endinterface

interface cscan_out_if;
  import cscan_pkg::*;
  logic              valid;
  logic              ready;
  logic [CYL_W-1:0]  position;
  logic              last;
  logic [SEEK_W-1:0] total_seek;
  logic [SEEK_W-1:0] average_seek;
  logic              no_requests;
  logic              overflow;
  modport source (output valid, position, last, total_seek, average_seek,
                  no_requests, overflow, input ready);
  modport sink   (input valid, position, last, total_seek, average_seek,
                  no_requests, overflow, output ready);
endinterface

interface cscan_cfg_if;
  import cscan_pkg::*;
  logic             valid;
  logic             ready;
  logic [CYL_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/cscan_disk_scheduler_top.sv -----
// Sequence: a start request insertion-sorts the stored requests (ST_SORT_RD,
// ST_SORT_CMP), scans the sorted list (ST_SCAN), computes the seek (ST_SEEK)
// and divides (ST_DIV); each result is read (ST_EMIT_RD) before it is valid.
// Throughput: one add request per cycle while idle; results wait on out_ready.
// Reset: synchronous active-low rst_n clears request count, overflow and FSM;
// max_cylinder resets to 199.
// ----------------------------------------------------------------------------
// cscan_disk_scheduler_top
// Circular-scan disk scheduler: request store, sorter and result stream.
// ----------------------------------------------------------------------------
module cscan_disk_scheduler_top import cscan_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  cscan_in_if.sink   in_ch,
  cscan_out_if.source out_ch,
  cscan_cfg_if.sink  cfg_ch
);

  logic [CYL_W-1:0] max_cyl_r;
  cmd_t cmd;
  sts_t sts;
  logic start_take, last_c;
  logic [SEEK_W-1:0] ts, av;
  logic nr, ov;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_cyl_r <= MAX_CYL_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      max_cyl_r <= cfg_ch.data;
    end
  end

  cscan_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_mode(in_ch.mode),
    .in_ready(in_ch.ready), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_last(last_c), .start_take, .cmd, .sts
  );

  cscan_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .in_cylinder(in_ch.cylinder), .max_cyl(max_cyl_r),
    .start_cyl(in_ch.cylinder), .start_take, .position(out_ch.position),
    .total_seek(ts), .average_seek(av), .no_requests(nr), .overflow(ov)
  );

  assign out_ch.last         = last_c;
  assign out_ch.total_seek   = last_c ? ts : '0;
  assign out_ch.average_seek = last_c ? av : '0;
  assign out_ch.no_requests  = last_c ? nr : 1'b0;
  assign out_ch.overflow     = last_c ? ov : 1'b0;

endmodule

// ----- rtl/cscan_ram.sv -----
// ----------------------------------------------------------------------------
// cscan_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module cscan_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/cscan_datapath.sv -----
// ----------------------------------------------------------------------------
// cscan_datapath
// Request store, insertion sort in RAM, scan bounds, seek and divider.
// ----------------------------------------------------------------------------
module cscan_datapath import cscan_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [CYL_W-1:0]  in_cylinder,
  input  logic [CYL_W-1:0]  max_cyl,
  input  logic [CYL_W-1:0]  start_cyl,
  input  logic              start_take,
  output logic [CYL_W-1:0]  position,
  output logic [SEEK_W-1:0] total_seek,
  output logic [SEEK_W-1:0] average_seek,
  output logic              no_requests,
  output logic              overflow
);

  // raw store and sorted store
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic              raw_we;
  logic [IDX_W-1:0]  raw_raddr;
  logic [CYL_W-1:0]  raw_rdata;
  logic              srt_we;
  logic [IDX_W-1:0]  srt_waddr, srt_raddr;
  logic [CYL_W-1:0]  srt_wdata, srt_rdata;

  // sort pointers: i = item being inserted, j = slot
  logic [CNT_W-1:0]  si_r, si_nxt, sj_r, sj_nxt;
  logic [CYL_W-1:0]  v_r, v_nxt;
  logic [CYL_W-1:0]  head_r, head_nxt;

  // scan results
  logic [CNT_W-1:0]  sk_r, sk_nxt, sk_pend_r, sk_pend_nxt;
  logic              sk_vld_r, sk_vld_nxt;
  logic [CNT_W-1:0]  lo_r, lo_nxt, eq_r, eq_nxt;
  logic [CYL_W-1:0]  low_nb_r, low_nb_nxt, hi_nb_r, hi_nb_nxt;
  logic              hi_seen_r, hi_seen_nxt;
  logic              left_r, left_nxt;

  // divider
  logic [SEEK_W-1:0] seek_r, seek_nxt, quo_r, quo_nxt;
  logic [SEEK_W:0]   rem_r, rem_nxt;
  logic [4:0]        dbit_r, dbit_nxt;

  // emission
  phase_t            ph_r, ph_nxt;
  logic [CNT_W-1:0]  ep_r, ep_nxt;

  logic [CNT_W-1:0]  n;
  logic [CYL_W-1:0]  clamp_in, cmp_val, higher_c;
  logic [SEEK_W:0]   rem_sh;
  logic              left_c, sort_ins_c, emit_mem_c, emit_last_c;
  logic              eq_ne, s1_ne, s2_ne, side_down;
  logic [CNT_W-1:0]  s1_first, s2_first, ph_stop, ep_step;

  assign n        = count_r;
  assign raw_we   = cmd.load && (count_r < CNT_W'(MAX_REQUESTS));
  assign clamp_in = (raw_rdata > max_cyl) ? max_cyl : raw_rdata;
  assign cmp_val  = (sj_r == si_r) ? clamp_in : v_r;
  assign sort_ins_c = (sj_r == '0) || !(srt_rdata > cmp_val);

  cscan_ram #(.WIDTH(CYL_W), .DEPTH(MAX_REQUESTS)) u_raw (
    .clk, .we(raw_we), .waddr(count_r[IDX_W-1:0]), .wdata(in_cylinder),
    .raddr(raw_raddr), .rdata(raw_rdata)
  );

  cscan_ram #(.WIDTH(CYL_W), .DEPTH(MAX_REQUESTS)) u_srt (
    .clk, .we(srt_we), .waddr(srt_waddr), .wdata(srt_wdata),
    .raddr(srt_raddr), .rdata(srt_rdata)
  );

  assign rem_sh = {rem_r[SEEK_W-1:0], seek_r[dbit_r]};

  assign higher_c = hi_seen_r ? hi_nb_r : max_cyl;
  assign left_c   = (lo_r != '0) && ((head_r - low_nb_r) < (higher_c - head_r));

  assign eq_ne     = (eq_r != lo_r);
  assign s1_ne     = left_r ? (lo_r != '0) : (eq_r != n);
  assign s2_ne     = left_r ? (n != eq_r) : (lo_r != '0);
  assign s1_first  = left_r ? (lo_r - CNT_W'(1)) : eq_r;
  assign s2_first  = left_r ? (n - CNT_W'(1)) : '0;
  assign side_down = left_r && (ph_r == PH_SIDE1 || ph_r == PH_SIDE2);
  assign ep_step   = side_down ? (ep_r - CNT_W'(1)) : (ep_r + CNT_W'(1));
  assign emit_mem_c = (ph_r == PH_EQ || ph_r == PH_SIDE1 || ph_r == PH_SIDE2);

  always_comb begin
    ph_stop = '0;
    unique case (ph_r)
      PH_EQ:    ph_stop = eq_r - CNT_W'(1);
      PH_SIDE1: ph_stop = left_r ? '0 : (n - CNT_W'(1));
      PH_SIDE2: ph_stop = left_r ? eq_r : (lo_r - CNT_W'(1));
      default:  ph_stop = '0;
    endcase
  end

  assign emit_last_c = (ph_r == PH_SIDE2 && ep_r == ph_stop) ||
                       (ph_r == PH_END2 && !s2_ne);

  always_comb begin
    sts.sort_done = (si_r == count_r);
    sts.sort_ins  = sort_ins_c;
    sts.scan_done = (sk_r == count_r);
    sts.div_done  = (dbit_r == '0);
    sts.emit_last = emit_last_c;
  end

  always_comb begin
    count_nxt   = count_r;
    ovf_nxt     = ovf_r;
    si_nxt      = si_r;
    sj_nxt      = sj_r;
    v_nxt       = v_r;
    head_nxt    = head_r;
    sk_nxt      = sk_r;
    sk_pend_nxt = sk_pend_r;
    sk_vld_nxt  = 1'b0;
    lo_nxt      = lo_r;
    eq_nxt      = eq_r;
    low_nb_nxt  = low_nb_r;
    hi_nb_nxt   = hi_nb_r;
    hi_seen_nxt = hi_seen_r;
    left_nxt    = left_r;
    seek_nxt    = seek_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    dbit_nxt    = dbit_r;
    ph_nxt      = ph_r;
    ep_nxt      = ep_r;
    srt_we      = 1'b0;
    srt_waddr   = sj_r[IDX_W-1:0];
    srt_wdata   = v_r;
    raw_raddr   = si_r[IDX_W-1:0];
    srt_raddr   = ep_r[IDX_W-1:0];

    if (cmd.load) begin
      if (count_r < CNT_W'(MAX_REQUESTS)) begin
        count_nxt = count_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    if (start_take) begin
      head_nxt = (start_cyl > max_cyl) ? max_cyl : start_cyl;
    end

    if (cmd.sort_init) begin
      si_nxt      = '0;
      sk_nxt      = '0;
      lo_nxt      = '0;
      eq_nxt      = '0;
      hi_seen_nxt = 1'b0;
    end

    if (cmd.sort_rd) begin
      sj_nxt    = si_r;
      srt_raddr = IDX_W'(si_r - CNT_W'(1));
    end

    if (cmd.sort_step) begin
      if (sj_r == si_r) begin
        v_nxt = clamp_in;
      end
      srt_we = 1'b1;
      if (sort_ins_c) begin
        srt_wdata = cmp_val;
        si_nxt    = si_r + CNT_W'(1);
      end else begin
        srt_wdata = srt_rdata;
        sj_nxt    = sj_r - CNT_W'(1);
        srt_raddr = IDX_W'(sj_r - CNT_W'(2));
      end
    end

    if (cmd.scan_step && (sk_r != count_r)) begin
      srt_raddr   = sk_r[IDX_W-1:0];
      sk_vld_nxt  = 1'b1;
      sk_pend_nxt = sk_r;
      sk_nxt      = sk_r + CNT_W'(1);
    end

    if (sk_vld_r) begin
      if (srt_rdata < head_r) begin
        lo_nxt     = sk_pend_r + CNT_W'(1);
        eq_nxt     = sk_pend_r + CNT_W'(1);
        low_nb_nxt = srt_rdata;
      end else if (srt_rdata == head_r) begin
        eq_nxt = sk_pend_r + CNT_W'(1);
      end else if (!hi_seen_r) begin
        hi_seen_nxt = 1'b1;
        hi_nb_nxt   = srt_rdata;
      end
    end

    // seek and restoring divider, one quotient bit per cycle
    if (cmd.div_init) begin
      left_nxt = left_c;
      if (left_c) begin
        seek_nxt = SEEK_W'(head_r) +
                   (hi_seen_r ? SEEK_W'(max_cyl - hi_nb_r) : '0);
      end else begin
        seek_nxt = SEEK_W'(max_cyl - head_r) +
                   ((lo_r != '0) ? SEEK_W'(low_nb_r) : '0);
      end
      rem_nxt  = '0;
      quo_nxt  = '0;
      dbit_nxt = 5'(SEEK_W - 1);
      ph_nxt   = PH_HEAD;
      ep_nxt   = '0;
    end
    if (cmd.div_step) begin
      if (rem_sh >= (SEEK_W+1)'(count_r)) begin
        rem_nxt = rem_sh - (SEEK_W+1)'(count_r);
        quo_nxt = {quo_r[SEEK_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[SEEK_W-2:0], 1'b0};
      end
      dbit_nxt = dbit_r - 5'd1;
    end

    if (cmd.emit_adv) begin
      if (emit_mem_c && ep_r != ph_stop) begin
        ep_nxt = ep_step;
      end else begin
        unique case (ph_r)
          PH_HEAD: begin
            if (eq_ne) begin
              ph_nxt = PH_EQ;
              ep_nxt = lo_r;
            end else if (s1_ne) begin
              ph_nxt = PH_SIDE1;
              ep_nxt = s1_first;
            end else begin
              ph_nxt = PH_END1;
            end
          end
          PH_EQ: begin
            if (s1_ne) begin
              ph_nxt = PH_SIDE1;
              ep_nxt = s1_first;
            end else begin
              ph_nxt = PH_END1;
            end
          end
          PH_SIDE1: ph_nxt = PH_END1;
          PH_END1:  ph_nxt = PH_END2;
          PH_END2: begin
            ph_nxt = PH_SIDE2;
            ep_nxt = s2_first;
          end
          default:  ph_nxt = ph_r;
        endcase
      end
    end

    if (cmd.clear) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end
  end

  always_comb begin
    unique case (ph_r)
      PH_HEAD:  position = head_r;
      PH_END1:  position = left_r ? '0 : max_cyl;
      PH_END2:  position = left_r ? max_cyl : '0;
      default:  position = srt_rdata;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      ovf_r    <= 1'b0;
      sk_vld_r <= 1'b0;
      ph_r     <= PH_HEAD;
    end else begin
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
      sk_vld_r <= sk_vld_nxt;
      ph_r     <= ph_nxt;
    end
    si_r      <= si_nxt;
    sj_r      <= sj_nxt;
    v_r       <= v_nxt;
    head_r    <= head_nxt;
    sk_r      <= sk_nxt;
    sk_pend_r <= sk_pend_nxt;
    lo_r      <= lo_nxt;
    eq_r      <= eq_nxt;
    low_nb_r  <= low_nb_nxt;
    hi_nb_r   <= hi_nb_nxt;
    hi_seen_r <= hi_seen_nxt;
    left_r    <= left_nxt;
    seek_r    <= seek_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    dbit_r    <= dbit_nxt;
    ep_r      <= ep_nxt;
  end

  assign total_seek   = seek_r;
  assign average_seek = (n == '0) ? '0 : quo_r;
  assign no_requests  = (n == '0);
  assign overflow     = ovf_r;

endmodule

// ----- rtl/cscan_ctrl.sv -----
// ----------------------------------------------------------------------------
// cscan_ctrl
// Controller: load, sort, scan, divide and emit sequencing.
// ----------------------------------------------------------------------------
module cscan_ctrl import cscan_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_mode,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output logic out_last,
  output logic start_take,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    out_last   = 1'b0;
    start_take = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_mode == MODE_ADD) begin
          cmd.load = 1'b1;
        end else if (in_valid) begin
          start_take    = 1'b1;
          cmd.sort_init = 1'b1;
          state_nxt     = ST_SORT_RD;
        end
      end
      ST_SORT_RD: begin
        if (sts.sort_done) begin
          state_nxt = ST_SCAN;
        end else begin
          cmd.sort_rd = 1'b1;
          state_nxt   = ST_SORT_CMP;
        end
      end
      ST_SORT_CMP: begin
        cmd.sort_step = 1'b1;
        state_nxt = sts.sort_ins ? ST_SORT_RD : ST_SORT_CMP;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_SEEK;
        end
      end
      ST_SEEK: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        out_last  = sts.emit_last;
        if (out_ready) begin
          cmd.emit_adv = 1'b1;
          if (sts.emit_last) begin
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/cscan_checker.sv -----
// ----------------------------------------------------------------------------
// cscan_checker
// Port-level checks on the result stream.
// ----------------------------------------------------------------------------
module cscan_checker import cscan_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic [SEEK_W-1:0] out_total_seek,
  input logic in_ready
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_total_seek == '0) else $error("seek off last");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken during emission");
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready) else $error("no return to idle");

endmodule

bind cscan_disk_scheduler_top cscan_checker u_chk (
  .clk, .rst_n, .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_last(out_ch.last), .out_total_seek(out_ch.total_seek),
  .in_ready(in_ch.ready)
);
